// File: rtl/core/qmm_pkg.sv
package qmm_pkg;

   // field widths
   localparam int CMD_W   = 16;
   localparam int STICK_W = 8;
   localparam int TRIM_W  = 12;
   localparam int MOTOR_W = 10;

   // internal datapath widths
   localparam int MIX_W   = 20;   // 3*lift_term + 2*yaw_term
   localparam int PROD_W  = 32;   // mix times gain unit
   localparam int RAD_W   = 28;   // clipped product divided by four
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int V_W     = 18;   // trimmed drive value before clamp

   // motors
   localparam int NUM_MOTORS  = 4;
   localparam int MOTOR_IDX_W = 2;
   localparam logic [MOTOR_IDX_W-1:0] M_FRONT = 2'd0;
   localparam logic [MOTOR_IDX_W-1:0] M_RIGHT = 2'd1;
   localparam logic [MOTOR_IDX_W-1:0] M_BACK  = 2'd2;
   localparam logic [MOTOR_IDX_W-1:0] M_LEFT  = 2'd3;

   // register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_TRIM_FRONT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TRIM_RIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TRIM_BACK  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_TRIM_LEFT  = 2'd3;

   // mixing constants: gains 6000 and 4000 share the factor 2000
   localparam int GAIN_UNIT       = 2000;
   localparam int SPIN_FLOOR      = 220;
   localparam int OVERLOAD_LIMIT  = 2000;
   localparam int STICK_THRESHOLD = 10;
   localparam int MOTOR_MAX_DEF   = 1000;

   typedef logic signed [CMD_W-1:0] cmd_type;

   typedef struct packed {
      cmd_type lift;
      cmd_type pitch;
      cmd_type yaw;
      cmd_type roll;
   } cmd_set_type;

endpackage

// File: rtl/core/quad_motor_mixer_isqrt.sv
// with the stick above threshold an accepted beat steps each of the four motors through
// the MIX, START and ROOT states around the 14-step square root unit; with the stick at
// or below threshold it goes straight to DONE. no new item is taken until the result is loaded.
// a finished result waits in the output register while the next item is taken.
// reset (synchronous, active high) clears the sequencer, the output valid and all trims.
module quad_motor_mixer_isqrt #(
   parameter int unsigned MOTOR_MAX = qmm_pkg::MOTOR_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qmm_pkg::CMD_W-1:0]    req_lift_cmd,
   input  logic signed [qmm_pkg::CMD_W-1:0]    req_pitch_cmd,
   input  logic signed [qmm_pkg::CMD_W-1:0]    req_yaw_cmd,
   input  logic signed [qmm_pkg::CMD_W-1:0]    req_roll_cmd,
   input  logic [qmm_pkg::STICK_W-1:0]         req_throttle_stick,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qmm_pkg::MOTOR_W-1:0]         rsp_motor_front,
   output logic [qmm_pkg::MOTOR_W-1:0]         rsp_motor_right,
   output logic [qmm_pkg::MOTOR_W-1:0]         rsp_motor_back,
   output logic [qmm_pkg::MOTOR_W-1:0]         rsp_motor_left,
   output logic                                rsp_motors_on,
   output logic                                rsp_overload,

   input  logic                                csr_we,
   input  logic [qmm_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [qmm_pkg::TRIM_W-1:0]          csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MIX   = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_ROOT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                               state_ff;
   logic [2:0]                               state_in;
   qmm_pkg::cmd_set_type                     cmds_ff;
   logic                                     on_ff;
   logic                                     over_ff;
   logic                                     over_in;
   logic [qmm_pkg::MOTOR_IDX_W-1:0]          motor_idx_ff;
   logic [qmm_pkg::MOTOR_IDX_W-1:0]          motor_idx_in;
   logic [qmm_pkg::MOTOR_W-1:0]              motor_val_ff [qmm_pkg::NUM_MOTORS];
   logic signed [qmm_pkg::TRIM_W-1:0]        trim_ff [qmm_pkg::NUM_MOTORS];
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   logic [qmm_pkg::MOTOR_W-1:0]              rsp_motor_ff [qmm_pkg::NUM_MOTORS];
   logic                                     rsp_on_ff;
   logic                                     rsp_over_ff;

   logic                                     req_take;
   logic                                     rsp_free;
   logic                                     rsp_load;
   logic                                     mix_load;
   logic                                     sq_start;
   logic                                     sq_done;
   logic [qmm_pkg::RAD_W-1:0]                rad;
   logic [qmm_pkg::ROOT_W-1:0]               root;
   logic [qmm_pkg::ROOT_W-1:0]               floored;
   logic signed [qmm_pkg::V_W-1:0]           trimmed;
   logic signed [qmm_pkg::V_W-1:0]           clamped;
   logic [qmm_pkg::MOTOR_W-1:0]              motor_val;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // mixer term for the current motor
   qmm_mix u_mix (
      .clock (clock),
      .load  (mix_load),
      .cmds  (cmds_ff),
      .motor (motor_idx_ff),
      .rad   (rad)
   );

   // shared square root unit
   qmm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (rad),
      .done  (sq_done),
      .root  (root)
   );

   // spin floor, trim and clamp on the finished root
   assign floored = (root < qmm_pkg::ROOT_W'(qmm_pkg::SPIN_FLOOR))
                  ? qmm_pkg::ROOT_W'(qmm_pkg::SPIN_FLOOR) : root;
   assign trimmed = $signed(qmm_pkg::V_W'(floored)) + qmm_pkg::V_W'(trim_ff[motor_idx_ff]);

   always_comb begin
      if (trimmed < 0) begin
         clamped = '0;
      end else if (trimmed > $signed(qmm_pkg::V_W'(MOTOR_MAX))) begin
         clamped = $signed(qmm_pkg::V_W'(MOTOR_MAX));
      end else begin
         clamped = trimmed;
      end
   end

   assign motor_val = clamped[qmm_pkg::MOTOR_W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      motor_idx_in = motor_idx_ff;
      over_in      = over_ff;
      mix_load     = 1'b0;
      sq_start     = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               motor_idx_in = qmm_pkg::M_FRONT;
               over_in      = 1'b0;
               if (req_throttle_stick > qmm_pkg::STICK_W'(qmm_pkg::STICK_THRESHOLD)) begin
                  state_in = ST_MIX;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MIX: begin
            mix_load = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            sq_start = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_done) begin
               if (root > qmm_pkg::ROOT_W'(qmm_pkg::OVERLOAD_LIMIT)) begin
                  over_in = 1'b1;
               end
               if (motor_idx_ff == qmm_pkg::M_LEFT) begin
                  state_in = ST_DONE;
               end else begin
                  motor_idx_in = motor_idx_ff + qmm_pkg::MOTOR_IDX_W'(1);
                  state_in     = ST_MIX;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and trims
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
            trim_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               qmm_pkg::REG_TRIM_FRONT: trim_ff[qmm_pkg::M_FRONT] <= csr_wdata;
               qmm_pkg::REG_TRIM_RIGHT: trim_ff[qmm_pkg::M_RIGHT] <= csr_wdata;
               qmm_pkg::REG_TRIM_BACK:  trim_ff[qmm_pkg::M_BACK]  <= csr_wdata;
               qmm_pkg::REG_TRIM_LEFT:  trim_ff[qmm_pkg::M_LEFT]  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // item payload and per-motor results
   always_ff @(posedge clock) begin
      motor_idx_ff <= motor_idx_in;
      over_ff      <= over_in;
      if (req_take) begin
         cmds_ff.lift  <= req_lift_cmd;
         cmds_ff.pitch <= req_pitch_cmd;
         cmds_ff.yaw   <= req_yaw_cmd;
         cmds_ff.roll  <= req_roll_cmd;
         on_ff         <= (req_throttle_stick > qmm_pkg::STICK_W'(qmm_pkg::STICK_THRESHOLD));
      end
      if ((state_ff == ST_ROOT) && sq_done) begin
         motor_val_ff[motor_idx_ff] <= motor_val;
      end
   end

   // output register: zeros when motors are off
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
            rsp_motor_ff[i] <= on_ff ? motor_val_ff[i] : '0;
         end
         rsp_on_ff   <= on_ff;
         rsp_over_ff <= on_ff && over_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_front = rsp_motor_ff[qmm_pkg::M_FRONT];
   assign rsp_motor_right = rsp_motor_ff[qmm_pkg::M_RIGHT];
   assign rsp_motor_back  = rsp_motor_ff[qmm_pkg::M_BACK];
   assign rsp_motor_left  = rsp_motor_ff[qmm_pkg::M_LEFT];
   assign rsp_motors_on   = rsp_on_ff;
   assign rsp_overload    = rsp_over_ff;

endmodule

// File: rtl/core/qmm_mix.sv
module qmm_mix (
   input  logic                                clock,
   input  logic                                load,
   input  qmm_pkg::cmd_set_type                cmds,
   input  logic [qmm_pkg::MOTOR_IDX_W-1:0]     motor,
   output logic [qmm_pkg::RAD_W-1:0]           rad
);

   logic signed [qmm_pkg::MIX_W-1:0]  lift_ext;
   logic signed [qmm_pkg::MIX_W-1:0]  pitch2;
   logic signed [qmm_pkg::MIX_W-1:0]  roll2;
   logic signed [qmm_pkg::MIX_W-1:0]  yaw_ext;
   logic signed [qmm_pkg::MIX_W-1:0]  lift_term;
   logic signed [qmm_pkg::MIX_W-1:0]  yaw_term;
   logic signed [qmm_pkg::MIX_W-1:0]  mix;
   logic signed [qmm_pkg::PROD_W-1:0] prod;
   logic [qmm_pkg::RAD_W-1:0]         rad_in;
   logic [qmm_pkg::RAD_W-1:0]         rad_ff;

   // sign-extend the commands
   assign lift_ext = qmm_pkg::MIX_W'(cmds.lift);
   assign pitch2   = qmm_pkg::MIX_W'(cmds.pitch) <<< 1;
   assign roll2    = qmm_pkg::MIX_W'(cmds.roll) <<< 1;
   assign yaw_ext  = qmm_pkg::MIX_W'(cmds.yaw);

   // plus-configuration terms per motor
   always_comb begin
      unique case (motor)
         qmm_pkg::M_FRONT: begin
            lift_term = lift_ext + pitch2;
            yaw_term  = -yaw_ext;
         end
         qmm_pkg::M_RIGHT: begin
            lift_term = lift_ext - roll2;
            yaw_term  = yaw_ext;
         end
         qmm_pkg::M_BACK: begin
            lift_term = lift_ext - pitch2;
            yaw_term  = -yaw_ext;
         end
         default: begin
            lift_term = lift_ext + roll2;
            yaw_term  = yaw_ext;
         end
      endcase
   end

   // 6000*a + 4000*b = 2000*(3a + 2b)
   assign mix  = (lift_term <<< 1) + lift_term + (yaw_term <<< 1);
   assign prod = qmm_pkg::PROD_W'(mix) * qmm_pkg::PROD_W'(qmm_pkg::GAIN_UNIT);

   // clip negative to zero, then divide by four
   assign rad_in = prod[qmm_pkg::PROD_W-1] ? '0 : prod[qmm_pkg::RAD_W+1:2];

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff <= rad_in;
      end
   end

   assign rad = rad_ff;

endmodule

// File: rtl/core/qmm_isqrt.sv
module qmm_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [qmm_pkg::RAD_W-1:0]      rad,
   output logic                           done,
   output logic [qmm_pkg::ROOT_W-1:0]     root
);

   localparam int CNT_W = $clog2(qmm_pkg::ROOT_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(qmm_pkg::ROOT_W - 1);

   logic                          busy_ff;
   logic                          busy_in;
   logic                          done_ff;
   logic                          done_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [qmm_pkg::RAD_W-1:0]     x_ff;
   logic [qmm_pkg::RAD_W-1:0]     x_in;
   logic [qmm_pkg::REM_W-1:0]     rem_ff;
   logic [qmm_pkg::REM_W-1:0]     rem_in;
   logic [qmm_pkg::ROOT_W-1:0]    root_ff;
   logic [qmm_pkg::ROOT_W-1:0]    root_in;
   logic [qmm_pkg::REM_W+1:0]     rem_sh;
   logic [qmm_pkg::REM_W+1:0]     trial;
   logic                          ge;

   // one result bit per step: bring down two radicand bits, try 4r+1
   assign rem_sh = {rem_ff, x_ff[qmm_pkg::RAD_W-1 -: 2]};
   assign trial  = {(qmm_pkg::REM_W - qmm_pkg::ROOT_W)'(0), root_ff, 2'b01};
   assign ge     = (rem_sh >= trial);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         x_in     = rad;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         x_in     = x_ff << 2;
         rem_in   = ge ? qmm_pkg::REM_W'(rem_sh - trial) : qmm_pkg::REM_W'(rem_sh);
         root_in  = {root_ff[qmm_pkg::ROOT_W-2:0], ge};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      x_ff     <= x_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
